// ===== src/chacha_pkg.sv =====
// chacha package: shared types, constants and word functions
`default_nettype none

package chacha_pkg;

  typedef logic [31:0] word_t;
  typedef word_t [15:0] state_t;

  // one classified request on its way from the front to the back
  typedef struct packed {
    logic [31:0] msg;
    logic [2:0]  vb;
    logic        last;
    logic [3:0]  pos;
    logic        new_block;
    logic [63:0] counter;
  } entry_t;

  // static cipher setup seen by the block generator
  typedef struct packed {
    logic [63:0] key01;
    logic [63:0] key23;
    logic [63:0] key45;
    logic [63:0] key67;
    logic        long_key;
    logic [63:0] nonce;
  } cfg_t;

  typedef struct packed {
    word_t a;
    word_t b;
    word_t c;
    word_t d;
  } quad_t;

  // configuration register indexes
  localparam logic [2:0] REG_KEY01    = 3'd0;
  localparam logic [2:0] REG_KEY23    = 3'd1;
  localparam logic [2:0] REG_KEY45    = 3'd2;
  localparam logic [2:0] REG_KEY67    = 3'd3;
  localparam logic [2:0] REG_LONG_KEY = 3'd4;
  localparam logic [2:0] REG_COUNTER  = 3'd5;
  localparam logic [2:0] REG_NONCE    = 3'd6;

  // "expand 32-byte k" and the differing words of "expand 16-byte k"
  localparam word_t SIGMA0 = 32'h6170_7865;
  localparam word_t SIGMA1 = 32'h3320_646e;
  localparam word_t SIGMA2 = 32'h7962_2d32;
  localparam word_t SIGMA3 = 32'h6b20_6574;
  localparam word_t TAU1   = 32'h3120_646e;
  localparam word_t TAU2   = 32'h7962_2d36;

  localparam int QUEUE_DEPTH = 4;
  localparam int QPTR_W      = 2;

  function automatic word_t rotl(word_t v, int unsigned n);
    return (v << n) | (v >> (32 - n));
  endfunction

  function automatic state_t input_state(cfg_t cfg, logic [63:0] ctr);
    state_t s;
    s[0]  = SIGMA0;
    s[1]  = cfg.long_key ? SIGMA1 : TAU1;
    s[2]  = cfg.long_key ? SIGMA2 : TAU2;
    s[3]  = SIGMA3;
    s[4]  = cfg.key01[31:0];
    s[5]  = cfg.key01[63:32];
    s[6]  = cfg.key23[31:0];
    s[7]  = cfg.key23[63:32];
    s[8]  = cfg.long_key ? cfg.key45[31:0]  : cfg.key01[31:0];
    s[9]  = cfg.long_key ? cfg.key45[63:32] : cfg.key01[63:32];
    s[10] = cfg.long_key ? cfg.key67[31:0]  : cfg.key23[31:0];
    s[11] = cfg.long_key ? cfg.key67[63:32] : cfg.key23[63:32];
    s[12] = ctr[31:0];
    s[13] = ctr[63:32];
    s[14] = cfg.nonce[31:0];
    s[15] = cfg.nonce[63:32];
    return s;
  endfunction

  // half of a quarter round: rotations 16/12 first, then 8/7
  function automatic quad_t half_qr(quad_t q, logic second);
    quad_t r;
    r = q;
    r.a = r.a + r.b;
    if (second) begin
      r.d = rotl(r.d ^ r.a, 8);
    end else begin
      r.d = rotl(r.d ^ r.a, 16);
    end
    r.c = r.c + r.d;
    if (second) begin
      r.b = rotl(r.b ^ r.c, 7);
    end else begin
      r.b = rotl(r.b ^ r.c, 12);
    end
    return r;
  endfunction

  function automatic word_t byte_mask(logic [2:0] vb);
    word_t m;
    case (vb)
      3'd0: m = 32'h0000_0000;
      3'd1: m = 32'h0000_00ff;
      3'd2: m = 32'h0000_ffff;
      3'd3: m = 32'h00ff_ffff;
      default: m = 32'hffff_ffff;
    endcase
    return m;
  endfunction

endpackage

`default_nettype wire

// ===== src/chacha_front.sv =====
// chacha front: tracks word position and block counter, tags each request
`default_nettype none

module chacha_front import chacha_pkg::*; (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        push,
  input  wire logic [31:0] message_word,
  input  wire logic [2:0]  valid_bytes,
  input  wire logic        last_word,
  input  wire logic        q_full,
  input  wire logic        reload,
  input  wire logic [63:0] reload_value,
  output logic             q_wr,
  output entry_t           q_entry
);

  logic [63:0] block_counter;
  logic [3:0]  word_position;

  assign q_wr = push && !q_full;

  always_comb begin
    q_entry.msg       = message_word;
    q_entry.vb        = valid_bytes;
    q_entry.last      = last_word;
    q_entry.pos       = word_position;
    q_entry.new_block = (word_position == 4'd0);
    q_entry.counter   = block_counter;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      block_counter <= 64'd0;
      word_position <= 4'd0;
    end else if (reload) begin
      block_counter <= reload_value;
      word_position <= 4'd0;
    end else if (q_wr) begin
      if (word_position == 4'd15 || last_word) begin
        block_counter <= block_counter + 64'd1;
        word_position <= 4'd0;
      end else begin
        word_position <= word_position + 4'd1;
      end
    end
  end

endmodule

`default_nettype wire

// ===== src/chacha_fifo.sv =====
// chacha fifo: short request queue between front and back
`default_nettype none

module chacha_fifo import chacha_pkg::*; (
  input  wire logic   clk,
  input  wire logic   rst,
  input  wire logic   wr,
  input  wire entry_t wr_entry,
  input  wire logic   rd,
  output logic        full,
  output logic        head_valid,
  output entry_t      head
);

  entry_t              slots [QUEUE_DEPTH];
  logic [QPTR_W-1:0]   wr_ptr;
  logic [QPTR_W-1:0]   rd_ptr;
  logic [QPTR_W:0]     count;

  assign full       = (count == (QPTR_W+1)'(QUEUE_DEPTH));
  assign head_valid = (count != '0);
  assign head       = slots[rd_ptr];

  always_ff @(posedge clk) begin
    if (wr && !full) begin
      slots[wr_ptr] <= wr_entry;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (wr && !full) begin
        wr_ptr <= wr_ptr + 1'b1;
      end
      if (rd && head_valid) begin
        rd_ptr <= rd_ptr + 1'b1;
      end
      case ({wr && !full, rd && head_valid})
        2'b10:   count <= count + 1'b1;
        2'b01:   count <= count - 1'b1;
        default: count <= count;
      endcase
    end
  end

endmodule

`default_nettype wire

// ===== src/chacha_back.sv =====
// chacha back: iterative block generator, keystream store and result register
`default_nettype none

module chacha_back import chacha_pkg::*; #(
  parameter int ROUND_COUNT = 20
) (
  input  wire logic   clk,
  input  wire logic   rst,
  input  wire cfg_t   cfg,
  input  wire logic   head_valid,
  input  wire entry_t head,
  output logic        q_rd,
  output logic        empty,
  input  wire logic   pop,
  output logic [31:0] cipher_word,
  output logic [2:0]  out_valid_bytes,
  output logic        out_last
);

  // four half-quarter-round steps per double round
  localparam int STEPS  = (ROUND_COUNT / 2) * 4;
  localparam int STEP_W = $clog2(STEPS);

  typedef enum logic [2:0] {
    S_IDLE  = 3'b001,
    S_ROUND = 3'b010,
    S_FINAL = 3'b100
  } st_t;

  st_t              st;
  state_t           x;
  state_t           x_step;
  state_t           in_st;
  logic [63:0]      blk_ctr;
  logic [STEP_W-1:0] step;
  logic             ks_fresh;
  logic             out_valid;
  logic             out_free;
  logic             need_gen;

  assign in_st    = input_state(cfg, blk_ctr);
  assign out_free = !out_valid || pop;
  assign need_gen = head.new_block && !ks_fresh;
  assign q_rd     = (st == S_IDLE) && head_valid && !need_gen && out_free;
  assign empty    = !out_valid;

  // four lanes of one half step; step[1] picks diagonal rounds
  always_comb begin
    quad_t      q;
    logic [1:0] jb;
    logic [1:0] jc;
    logic [1:0] jd;
    x_step = x;
    for (int j = 0; j < 4; j++) begin
      jb = 2'(j) + (step[1] ? 2'd1 : 2'd0);
      jc = 2'(j) + (step[1] ? 2'd2 : 2'd0);
      jd = 2'(j) + (step[1] ? 2'd3 : 2'd0);
      q.a = x[{2'b00, 2'(j)}];
      q.b = x[{2'b01, jb}];
      q.c = x[{2'b10, jc}];
      q.d = x[{2'b11, jd}];
      q = half_qr(q, step[0]);
      x_step[{2'b00, 2'(j)}] = q.a;
      x_step[{2'b01, jb}]    = q.b;
      x_step[{2'b10, jc}]    = q.c;
      x_step[{2'b11, jd}]    = q.d;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      st        <= S_IDLE;
      step      <= '0;
      ks_fresh  <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      // result register: loaded on a queue read, freed on a pop
      if (q_rd) begin
        out_valid <= 1'b1;
      end else if (pop && out_valid) begin
        out_valid <= 1'b0;
      end
      case (st)
        S_IDLE: begin
          if (head_valid && need_gen) begin
            x       <= input_state(cfg, head.counter);
            blk_ctr <= head.counter;
            step    <= '0;
            st      <= S_ROUND;
          end else if (q_rd) begin
            cipher_word     <= (head.msg ^ x[head.pos]) & byte_mask(head.vb);
            out_valid_bytes <= head.vb;
            out_last        <= head.last;
            ks_fresh        <= 1'b0;
          end
        end
        S_ROUND: begin
          x    <= x_step;
          step <= step + 1'b1;
          if (step == STEP_W'(STEPS - 1)) begin
            st <= S_FINAL;
          end
        end
        S_FINAL: begin
          for (int i = 0; i < 16; i++) begin
            x[i] <= x[i] + in_st[i];
          end
          ks_fresh <= 1'b1;
          st       <= S_IDLE;
        end
        default: st <= S_IDLE;
      endcase
    end
  end

endmodule

`default_nettype wire

// ===== src/chacha20_stream_cipher_top.sv =====
// chacha20 stream cipher top level: configuration registers, front, queue, back
//
//  channel   handshake          payload                                 note
//  input     push / full        message_word, valid_bytes, last_word    request in
//  result    empty / pop        cipher_word, out_valid_bytes, out_last  oldest first
//  config    wr_en              wr_index, wr_data                       no wait, no read-back
//
//  a request that needs no new keystream block leaves the queue once the back is idle and the result register is free
//  a request at word position 0 first waits for a new keystream block from the shared
//  round unit, which runs the round steps (S_ROUND) and then the final addition (S_FINAL)
//  rst is synchronous and active high; no clearing pass is needed after it
//  a stalled pop backs up the result register, then the queue, then full
`default_nettype none

module chacha20_stream_cipher_top import chacha_pkg::*; #(
  parameter int ROUND_COUNT = 20
) (
  input  wire logic        clk,
  input  wire logic        rst,
  // request input
  input  wire logic        push,
  output logic             full,
  input  wire logic [31:0] message_word,
  input  wire logic [2:0]  valid_bytes,
  input  wire logic        last_word,
  // result output
  output logic             empty,
  input  wire logic        pop,
  output logic [31:0]      cipher_word,
  output logic [2:0]       out_valid_bytes,
  output logic             out_last,
  // configuration writes
  input  wire logic        wr_en,
  input  wire logic [2:0]  wr_index,
  input  wire logic [63:0] wr_data
);

  cfg_t   cfg;
  entry_t q_wr_entry;
  entry_t q_head;
  logic   q_wr;
  logic   q_rd;
  logic   q_full;
  logic   q_head_valid;
  logic   reload;

  // writing the counter register reloads the running counter in the front
  assign reload = wr_en && (wr_index == REG_COUNTER);
  assign full   = q_full;

  // static setup registers; an index beyond the list is ignored
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.key01    <= 64'd0;
      cfg.key23    <= 64'd0;
      cfg.key45    <= 64'd0;
      cfg.key67    <= 64'd0;
      cfg.long_key <= 1'b1;
      cfg.nonce    <= 64'd0;
    end else if (wr_en) begin
      case (wr_index)
        REG_KEY01:    cfg.key01    <= wr_data;
        REG_KEY23:    cfg.key23    <= wr_data;
        REG_KEY45:    cfg.key45    <= wr_data;
        REG_KEY67:    cfg.key67    <= wr_data;
        REG_LONG_KEY: cfg.long_key <= wr_data[0];
        REG_NONCE:    cfg.nonce    <= wr_data;
        default: ;
      endcase
    end
  end

  // front: position and block counter bookkeeping per request
  chacha_front u_front (
    .clk          (clk),
    .rst          (rst),
    .push         (push),
    .message_word (message_word),
    .valid_bytes  (valid_bytes),
    .last_word    (last_word),
    .q_full       (q_full),
    .reload       (reload),
    .reload_value (wr_data),
    .q_wr         (q_wr),
    .q_entry      (q_wr_entry)
  );

  // queue decouples intake from block generation
  chacha_fifo u_fifo (
    .clk        (clk),
    .rst        (rst),
    .wr         (q_wr),
    .wr_entry   (q_wr_entry),
    .rd         (q_rd),
    .full       (q_full),
    .head_valid (q_head_valid),
    .head       (q_head)
  );

  // back: round unit, keystream words and result register
  chacha_back #(
    .ROUND_COUNT (ROUND_COUNT)
  ) u_back (
    .clk             (clk),
    .rst             (rst),
    .cfg             (cfg),
    .head_valid      (q_head_valid),
    .head            (q_head),
    .q_rd            (q_rd),
    .empty           (empty),
    .pop             (pop),
    .cipher_word     (cipher_word),
    .out_valid_bytes (out_valid_bytes),
    .out_last        (out_last)
  );

endmodule

`default_nettype wire
